### src/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int unsigned HueW = 17;
  localparam int unsigned ChanW = 8;

  // hue codes, 1/128 degree
  localparam logic [15:0] HUE_SECTOR = 16'd7680;
  localparam logic [15:0] HUE_TWO_SECTORS = 16'd15360;
  localparam logic [15:0] HUE_FULL = 16'd46080;

  localparam logic [7:0] FULL_SCALE = 8'd255;
  localparam logic [15:0] ROUND_LO = 16'd127;
  // half of 255*7680, the rounding bias for the middle channel
  localparam logic [28:0] HALF_DENOM = 29'd979200;
  // 255*7680 = 512*3825; floor(2^32/3825) for the reciprocal
  localparam logic [20:0] RECIP_3825 = 21'd1122867;
  localparam logic [19:0] DIV_3825 = 20'd3825;
  localparam logic [23:0] RECIP_255 = 24'd257;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // after the first stage: products and hue geometry
  typedef struct packed {
    logic [15:0] grey_prod;   // v*(255-s)
    logic [15:0] chroma_prod; // v*s
    logic [12:0] ramp;        // 0..7680
    sector_t sector;
    logic in_range;
    logic [7:0] bright;
  } s1_t;

  // after the second stage: middle numerator >> 9, low channel estimate
  typedef struct packed {
    logic [19:0] mid_num;
    logic [15:0] lo_num;
    logic [7:0] lo_est;
    sector_t sector;
    logic in_range;
    logic [7:0] bright;
  } s2_t;

  // after the third stage: low channel final, middle channel estimate
  typedef struct packed {
    logic [19:0] mid_num;
    logic [7:0] mid_est;
    logic [7:0] lo;
    sector_t sector;
    logic in_range;
    logic [7:0] bright;
  } s3_t;

endpackage

### src/hsv2rgb_prep.sv
module hsv2rgb_prep import hsv2rgb_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld_in,
  input  logic [HueW-1:0] hue,
  input  logic [7:0]      sat,
  input  logic [7:0]      bright,
  output logic            vld_out,
  output s1_t             s1_out
);

  logic        vld_r;
  s1_t         s1_r;
  s1_t         s1_nxt;
  logic [15:0] hue_u;
  logic [15:0] pair_base;
  logic [13:0] pair_pos;
  logic [7:0]  sat_inv;

  always_comb begin
    hue_u = hue[15:0];
    sat_inv = FULL_SCALE - sat;
    s1_nxt.grey_prod = 16'(bright) * 16'(sat_inv);
    s1_nxt.chroma_prod = 16'(bright) * 16'(sat);
    s1_nxt.in_range = !hue[HueW-1] && (hue_u < HUE_FULL);
    s1_nxt.bright = bright;

    if (hue_u < HUE_SECTOR) begin
      s1_nxt.sector = SEC_RED_YEL;
    end else if (hue_u < 16'(2 * HUE_SECTOR)) begin
      s1_nxt.sector = SEC_YEL_GRN;
    end else if (hue_u < 16'(3 * HUE_SECTOR)) begin
      s1_nxt.sector = SEC_GRN_CYN;
    end else if (hue_u < 16'(4 * HUE_SECTOR)) begin
      s1_nxt.sector = SEC_CYN_BLU;
    end else if (hue_u < 16'(5 * HUE_SECTOR)) begin
      s1_nxt.sector = SEC_BLU_MAG;
    end else begin
      s1_nxt.sector = SEC_MAG_RED;
    end

    // position inside the current 120 degree pair of sectors
    if (hue_u < HUE_TWO_SECTORS) begin
      pair_base = 16'd0;
    end else if (hue_u < 16'(2 * HUE_TWO_SECTORS)) begin
      pair_base = HUE_TWO_SECTORS;
    end else begin
      pair_base = 16'(2 * HUE_TWO_SECTORS);
    end
    pair_pos = 14'(hue_u - pair_base);

    // triangle: rises over the first sector, falls over the second
    if (pair_pos < 14'(HUE_SECTOR)) begin
      s1_nxt.ramp = pair_pos[12:0];
    end else begin
      s1_nxt.ramp = 13'(14'(HUE_TWO_SECTORS) - pair_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    s1_r <= s1_nxt;
  end

  assign vld_out = vld_r;
  assign s1_out = s1_r;

endmodule

### src/hsv2rgb_div.sv
module hsv2rgb_div import hsv2rgb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_in,
  input  s1_t  s1_in,
  output logic vld_out,
  output s3_t  s3_out
);

  logic        vld2_r;
  logic        vld3_r;
  s2_t         s2_r;
  s2_t         s2_nxt;
  s3_t         s3_r;
  s3_t         s3_nxt;
  logic [28:0] mid_full;
  logic [23:0] lo_prod;
  logic [40:0] mid_prod;
  logic [16:0] lo_rem;

  // second stage: full middle numerator, low channel reciprocal
  always_comb begin
    mid_full = 29'(s1_in.grey_prod) * 29'(HUE_SECTOR)
             + 29'(s1_in.chroma_prod) * 29'(s1_in.ramp)
             + HALF_DENOM;
    s2_nxt.mid_num = mid_full[28:9];
    s2_nxt.lo_num = s1_in.grey_prod + ROUND_LO;
    lo_prod = 24'(s2_nxt.lo_num) * RECIP_255;
    s2_nxt.lo_est = lo_prod[23:16];
    s2_nxt.sector = s1_in.sector;
    s2_nxt.in_range = s1_in.in_range;
    s2_nxt.bright = s1_in.bright;
  end

  // third stage: estimate may sit one below the quotient
  always_comb begin
    mid_prod = 41'(s2_r.mid_num) * 41'(RECIP_3825);
    s3_nxt.mid_num = s2_r.mid_num;
    s3_nxt.mid_est = mid_prod[39:32];
    lo_rem = 17'(s2_r.lo_num) - 17'(s2_r.lo_est) * 17'(FULL_SCALE);
    s3_nxt.lo = s2_r.lo_est + 8'(lo_rem >= 17'(FULL_SCALE));
    s3_nxt.sector = s2_r.sector;
    s3_nxt.in_range = s2_r.in_range;
    s3_nxt.bright = s2_r.bright;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else begin
      vld2_r <= vld_in;
      vld3_r <= vld2_r;
    end
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

  assign vld_out = vld3_r;
  assign s3_out = s3_r;

endmodule

### src/hsv2rgb_mix.sv
module hsv2rgb_mix import hsv2rgb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_in,
  input  s3_t              s3_in,
  output logic             vld_out,
  output logic [ChanW-1:0] red,
  output logic [ChanW-1:0] green,
  output logic [ChanW-1:0] blue
);

  logic             vld_r;
  logic [ChanW-1:0] red_r;
  logic [ChanW-1:0] green_r;
  logic [ChanW-1:0] blue_r;
  logic [ChanW-1:0] red_nxt;
  logic [ChanW-1:0] green_nxt;
  logic [ChanW-1:0] blue_nxt;
  logic [19:0]      mid_rem;
  logic [ChanW-1:0] mid;
  logic [ChanW-1:0] lo;
  logic [ChanW-1:0] hi;

  always_comb begin
    mid_rem = s3_in.mid_num - 20'(s3_in.mid_est) * DIV_3825;
    mid = s3_in.mid_est + 8'(mid_rem >= DIV_3825);
    lo = s3_in.lo;
    hi = s3_in.bright;
    red_nxt = lo;
    green_nxt = lo;
    blue_nxt = lo;
    if (s3_in.in_range) begin
      unique case (s3_in.sector)
        SEC_RED_YEL: begin
          red_nxt = hi;
          green_nxt = mid;
        end
        SEC_YEL_GRN: begin
          red_nxt = mid;
          green_nxt = hi;
        end
        SEC_GRN_CYN: begin
          green_nxt = hi;
          blue_nxt = mid;
        end
        SEC_CYN_BLU: begin
          green_nxt = mid;
          blue_nxt = hi;
        end
        SEC_BLU_MAG: begin
          red_nxt = mid;
          blue_nxt = hi;
        end
        default: begin
          red_nxt = hi;
          blue_nxt = mid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
    red_r <= red_nxt;
    green_r <= green_nxt;
    blue_r <= blue_nxt;
  end

  assign vld_out = vld_r;
  assign red = red_r;
  assign green = green_r;
  assign blue = blue_r;

endmodule

### src/hsv_to_rgb_pixel_unit.sv
// channel   dir  handshake        beat
// in        in   start & !busy    in_hue, in_saturation, in_brightness
// out       out  out_valid        out_red, out_green, out_blue
//
// Four register stages; one beat accepted every cycle.
// The stage count is set by the two reciprocal divides (by 255 and by 255*7680) and
// their one-step corrections, each split over its own stage.
// busy is always low: nothing inside can fill up.
// Synchronous active-low reset clears only the valid bits.
// The receiver cannot stall; each result shows for one cycle.
module hsv_to_rgb_pixel_unit import hsv2rgb_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [HueW-1:0]  in_hue,
  input  logic [7:0]       in_saturation,
  input  logic [7:0]       in_brightness,
  output logic             out_valid,
  output logic [ChanW-1:0] out_red,
  output logic [ChanW-1:0] out_green,
  output logic [ChanW-1:0] out_blue
);

  logic take;
  logic vld1;
  logic vld3;
  s1_t  s1;
  s3_t  s3;

  assign busy = 1'b0;
  assign take = start && !busy;

  hsv2rgb_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (take),
    .hue     (in_hue),
    .sat     (in_saturation),
    .bright  (in_brightness),
    .vld_out (vld1),
    .s1_out  (s1)
  );

  hsv2rgb_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (vld1),
    .s1_in   (s1),
    .vld_out (vld3),
    .s3_out  (s3)
  );

  hsv2rgb_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_in  (vld3),
    .s3_in   (s3),
    .vld_out (out_valid),
    .red     (out_red),
    .green   (out_green),
    .blue    (out_blue)
  );

`ifndef SYNTHESIS
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##4 out_valid)
    else $error("accepted beat produced no result");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(take, 4))
    else $error("result without an accepted beat");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_hue[HueW-1], 4) |->
      (out_red == out_green) && (out_green == out_blue))
    else $error("negative hue did not give grey");

  a_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(!in_hue[HueW-1] && (in_hue[15:0] < HUE_FULL), 4) |->
      (out_red == $past(in_brightness, 4)) || (out_green == $past(in_brightness, 4)) ||
      (out_blue == $past(in_brightness, 4)))
    else $error("no channel equals brightness");
`endif

endmodule
